// File: hw/rtl/b64le_pkg.sv
// shared types, constants and the base64 alphabet for the line encoder
package b64le_pkg;

    localparam int LINE_BYTES = 48;
    localparam int LC_W       = $clog2(LINE_BYTES);
    localparam int SP_W       = 6;
    localparam logic [SP_W-1:0] MAX_INDENT = 6'd59;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_PAD   = 8'h3D;

    // configuration register indexes
    localparam logic CFG_INDENT_ENABLE = 1'b0;
    localparam logic CFG_INDENT_SPACES = 1'b1;

    typedef enum logic [1:0] {
        GRP_NONE,
        GRP_FULL,
        GRP_PAD1,
        GRP_PAD2
    } grp_kind_t;

    typedef struct packed {
        logic [SP_W-1:0] spaces;
        grp_kind_t       kind;
        logic [7:0]      byte0;
        logic [7:0]      byte1;
        logic [7:0]      byte2;
        logic            newline;
    } cmd_t;

    typedef struct packed {
        logic            indent_enable;
        logic [SP_W-1:0] indent_spaces;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)
        begin
            r = 8'd65 + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            r = 8'd71 + {2'b00, v};
        end
        else if (v < 6'd62)
        begin
            r = {2'b00, v} - 8'd4;
        end
        else if (v == 6'd62)
        begin
            r = 8'h2B;
        end
        else
        begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/b64le_front.sv
// front end: takes bytes, tracks group and line position, issues char commands
module b64le_front
    import b64le_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       fifo_full,
    output logic       push,
    output cmd_t       cmd
);

    logic [7:0]      held0_reg, held0_next;
    logic [7:0]      held1_reg, held1_next;
    logic [1:0]      gc_reg, gc_next;
    logic [LC_W-1:0] lc_reg, lc_next;
    logic            open_reg, open_next;

    logic            accept;
    logic [SP_W-1:0] sp_clamp;
    logic [1:0]      gc_after;
    logic            group_full;
    logic [LC_W:0]   lc_inc;
    logic            close;

    always_comb
    begin
        accept     = in_valid && !fifo_full;
        in_ready   = !fifo_full;
        sp_clamp   = (cfg.indent_spaces > MAX_INDENT) ? MAX_INDENT : cfg.indent_spaces;
        group_full = (gc_reg >= 2'd2);
        case (gc_reg)
            2'd0:    gc_after = 2'd1;
            2'd1:    gc_after = 2'd2;
            default: gc_after = 2'd0;
        endcase
        lc_inc = {1'b0, lc_reg} + {{LC_W{1'b0}}, 1'b1};
        close  = (lc_inc >= (LC_W+1)'(LINE_BYTES)) || in_last;

        cmd.spaces = (!open_reg && cfg.indent_enable) ? sp_clamp : '0;
        if (group_full)
        begin
            cmd.kind = GRP_FULL;
        end
        else if (close)
        begin
            cmd.kind = (gc_after == 2'd1) ? GRP_PAD1 : GRP_PAD2;
        end
        else
        begin
            cmd.kind = GRP_NONE;
        end
        cmd.byte0   = (gc_reg == 2'd0) ? in_byte : held0_reg;
        cmd.byte1   = (gc_reg == 2'd1) ? in_byte : held1_reg;
        cmd.byte2   = in_byte;
        cmd.newline = close && cfg.indent_enable;

        push = accept && ((cmd.spaces != '0) || (cmd.kind != GRP_NONE) || cmd.newline);

        held0_next = (gc_reg == 2'd0) ? in_byte : held0_reg;
        held1_next = (gc_reg == 2'd1) ? in_byte : held1_reg;
        gc_next    = close ? 2'd0 : gc_after;
        lc_next    = close ? '0 : lc_inc[LC_W-1:0];
        open_next  = !close;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held0_reg <= '0;
            held1_reg <= '0;
            gc_reg    <= '0;
            lc_reg    <= '0;
            open_reg  <= 1'b0;
        end
        else if (accept)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            gc_reg    <= gc_next;
            lc_reg    <= lc_next;
            open_reg  <= open_next;
        end
    end

endmodule

// File: hw/rtl/b64le_fifo.sv
// short command queue between front and back end
module b64le_fifo
    import b64le_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  cmd_t         din,
    input  logic         pop,
    output cmd_t         head,
    output fifo_status_t status
);

    cmd_t mem [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;

    always_comb
    begin
        status.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
        status.empty = (count_reg == '0);
        head         = mem[rd_ptr_reg];
        count_next   = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/b64le_back.sv
// back end: walks the head command into the output register one character per cycle unless the receiver stalls
module b64le_back
    import b64le_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       head_valid,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_last
);

    logic [SP_W-1:0] sp_done_reg, sp_done_next;
    logic [2:0]      sym_done_reg, sym_done_next;
    logic            out_valid_reg;
    logic [7:0]      out_char_reg;
    logic            out_last_reg;

    logic            emit;
    logic            in_spaces;
    logic            in_syms;
    logic            final_char;
    logic [7:0]      char_now;
    logic [7:0]      sym_char;
    logic [7:0]      a, c, b;

    always_comb
    begin
        a = head.byte0;
        c = head.byte1;
        b = head.byte2;
        case (sym_done_reg[1:0])
            2'd0: sym_char = b64_sym(a[7:2]);
            2'd1:
            begin
                if (head.kind == GRP_PAD1)
                begin
                    sym_char = b64_sym({a[1:0], 4'b0000});
                end
                else
                begin
                    sym_char = b64_sym({a[1:0], c[7:4]});
                end
            end
            2'd2:
            begin
                case (head.kind)
                    GRP_FULL: sym_char = b64_sym({c[3:0], b[7:6]});
                    GRP_PAD2: sym_char = b64_sym({c[3:0], 2'b00});
                    default:  sym_char = CH_PAD;
                endcase
            end
            default: sym_char = (head.kind == GRP_FULL) ? b64_sym(b[5:0]) : CH_PAD;
        endcase

        emit      = head_valid && (!out_valid_reg || out_ready);
        in_spaces = (sp_done_reg != head.spaces);
        in_syms   = !in_spaces && (head.kind != GRP_NONE) && (sym_done_reg != 3'd4);

        if (in_spaces)
        begin
            char_now   = CH_SPACE;
            final_char = ((sp_done_reg + 1'b1) == head.spaces) && (head.kind == GRP_NONE)
                         && !head.newline;
        end
        else if (in_syms)
        begin
            char_now   = sym_char;
            final_char = (sym_done_reg == 3'd3) && !head.newline;
        end
        else
        begin
            char_now   = CH_NL;
            final_char = 1'b1;
        end

        pop           = emit && final_char;
        sp_done_next  = sp_done_reg;
        sym_done_next = sym_done_reg;
        if (emit)
        begin
            if (final_char)
            begin
                sp_done_next  = '0;
                sym_done_next = '0;
            end
            else if (in_spaces)
            begin
                sp_done_next = sp_done_reg + 1'b1;
            end
            else
            begin
                sym_done_next = sym_done_reg + 1'b1;
            end
        end

        out_valid = out_valid_reg;
        out_char  = out_char_reg;
        out_last  = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_done_reg   <= '0;
            sym_done_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_done_reg  <= sp_done_next;
            sym_done_reg <= sym_done_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_char_reg <= char_now;
            out_last_reg <= final_char;
        end
    end

endmodule

// File: hw/rtl/base64_line_encoder.sv
// top level of the streaming base64 encoder with optional line framing
//
// usage:
//   raw bytes enter on the s_ side, one per transfer, s_tlast marking the
//   final byte; characters leave on the m_ side, one per transfer, with
//   m_tlast on the last character caused by an input byte
//   every third byte of a group yields four base64 characters; lines hold
//   48 input bytes, and in indent mode each line opens with indent_spaces
//   spaces (at most 59) and closes with a newline
//   a byte that yields no characters leaves no output at all
//   a byte's command enters the queue at its transfer edge; its first
//   character then reaches m_ through the output register
//   throughput: the front takes one byte per cycle while the four-entry
//   command queue has room; the back end emits one character per cycle
//   unless the receiver stalls, and a byte causes 0 to 64 characters
//   when the receiver stalls, the output register holds its character, the
//   back end waits, the queue fills and then s_tready drops
//   reset clears the group and line position, the queue and both config
//   registers (indent off, zero spaces)
//   config writes are taken at any edge with cfg_we high, meant while idle
module base64_line_encoder
    import b64le_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [5:0] cfg_data,
    // input byte stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    // output character stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // run_last
);

    cfg_t         cfg_reg;
    cmd_t         front_cmd;
    cmd_t         head_cmd;
    logic         push;
    logic         pop;
    fifo_status_t fifo_status;

    // config registers, written by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INDENT_ENABLE: cfg_reg.indent_enable <= cfg_data[0];
                CFG_INDENT_SPACES: cfg_reg.indent_spaces <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front end: byte grouping and line position
    b64le_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .fifo_full (fifo_status.full),
        .push      (push),
        .cmd       (front_cmd)
    );

    // command queue decouples intake from character output
    b64le_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (front_cmd),
        .pop    (pop),
        .head   (head_cmd),
        .status (fifo_status)
    );

    // back end: one character per cycle unless the receiver stalls
    b64le_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_valid (!fifo_status.empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

    // no command is written into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && fifo_status.full))
        else $error("command pushed into full queue");

    // no command is retired from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && fifo_status.empty))
        else $error("command popped from empty queue");

    // a newline always closes the characters of its byte
    a_nl_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata == CH_NL)) |-> m_tlast)
        else $error("newline not marked as last character");

endmodule
